// ===== rtl/core/qfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared constants, the sine table builder and the lookup struct of the
// quadrature frequency shifter.
// ----------------------------------------------------------------------------
package qfs_pkg;

  // default configuration
  localparam int SAMPLE_WIDTH    = 16;
  localparam int PHASE_WIDTH     = 32;
  localparam int TABLE_ADDR_BITS = 10;

  // register width and table value width (Q1.15)
  localparam int STEP_WIDTH  = 32;
  localparam int TRIG_WIDTH  = 16;
  localparam int FRAC_SHIFT  = 15;
  localparam int ROUND_HALF  = 16384;

  // table generation constants
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TRIG_MAX    = 64'd32767;

  // sine and cosine magnitudes from the table plus their quadrant signs
  typedef struct packed {
    logic [TRIG_WIDTH-1:0] sin_mag;
    logic [TRIG_WIDTH-1:0] cos_mag;
    logic                  sin_neg;
    logic                  cos_neg;
  } trig_t;

  // quarter-wave sine entry k of a table with 2^addr_bits steps
  function automatic logic [TRIG_WIDTH-1:0] sine_entry(input int unsigned k,
                                                       input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    x  = (64'(k) * HALF_PI_Q30) >> addr_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    // horner form of the sine series, innermost term first
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    e  = (s * TRIG_MAX + (Q30_ONE >> 1)) >> 30;
    return (e > TRIG_MAX) ? TRIG_MAX[TRIG_WIDTH-1:0] : e[TRIG_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qfs_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfs_sine_rom
// Quarter-wave sine table with two registered read ports, one for the sine
// and one for the cosine lookup.
// ----------------------------------------------------------------------------
module qfs_sine_rom #(
  parameter int TABLE_ADDR_BITS = qfs_pkg::TABLE_ADDR_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [TABLE_ADDR_BITS:0]         addr_a,
  input  wire logic [TABLE_ADDR_BITS:0]         addr_b,
  output logic      [qfs_pkg::TRIG_WIDTH-1:0]   data_a,
  output logic      [qfs_pkg::TRIG_WIDTH-1:0]   data_b
);

  localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

  logic [qfs_pkg::TRIG_WIDTH-1:0] rom [DEPTH];

  // constant contents, entries zero to a quarter turn inclusive
  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = qfs_pkg::sine_entry(k, TABLE_ADDR_BITS);
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/qfs_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qfs_mixer
// Complex mixer: applies the quadrant signs, forms the four products, then
// sums, rounds half up and saturates to the sample width; bypass passes input.
// ----------------------------------------------------------------------------
module qfs_mixer #(
  parameter int SAMPLE_WIDTH = qfs_pkg::SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           en_mul,
  input  wire logic                           en_out,
  input  wire qfs_pkg::trig_t                 trig,
  input  wire logic                           bypass,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_q,
  output logic signed      [SAMPLE_WIDTH-1:0] y_i,
  output logic signed      [SAMPLE_WIDTH-1:0] y_q
);

  localparam int CW = qfs_pkg::TRIG_WIDTH + 1;
  localparam int PW = SAMPLE_WIDTH + CW;
  localparam int AW = PW + 1;

  logic signed [CW-1:0] s_val;
  logic signed [CW-1:0] c_val;

  logic signed [PW-1:0] p_si;
  logic signed [PW-1:0] p_cq;
  logic signed [PW-1:0] p_sq;
  logic signed [PW-1:0] p_ci;
  logic                 bypass_m;
  logic signed [SAMPLE_WIDTH-1:0] x_i_m;
  logic signed [SAMPLE_WIDTH-1:0] x_q_m;

  logic signed [AW-1:0] sum_i;
  logic signed [AW-1:0] sum_q;
  logic signed [AW-1:0] rnd_i;
  logic signed [AW-1:0] rnd_q;
  logic signed [SAMPLE_WIDTH-1:0] sat_i;
  logic signed [SAMPLE_WIDTH-1:0] sat_q;

  // signed sine and cosine from table magnitude and quadrant
  always_comb begin
    s_val = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
    c_val = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});
  end

  // product stage
  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_si     <= PW'(s_val) * PW'(x_i);
      p_cq     <= PW'(c_val) * PW'(x_q);
      p_sq     <= PW'(s_val) * PW'(x_q);
      p_ci     <= PW'(c_val) * PW'(x_i);
      bypass_m <= bypass;
      x_i_m    <= x_i;
      x_q_m    <= x_q;
    end
  end

  // sum, round half up by flooring after adding one half
  always_comb begin
    sum_i = AW'(p_si) + AW'(p_cq);
    sum_q = AW'(p_sq) - AW'(p_ci);
    rnd_i = (sum_i + AW'(qfs_pkg::ROUND_HALF)) >>> qfs_pkg::FRAC_SHIFT;
    rnd_q = (sum_q + AW'(qfs_pkg::ROUND_HALF)) >>> qfs_pkg::FRAC_SHIFT;
  end

  // clamp to the signed sample range when the upper bits disagree
  always_comb begin
    if (rnd_i[AW-1:SAMPLE_WIDTH-1] == '0 || rnd_i[AW-1:SAMPLE_WIDTH-1] == '1) begin
      sat_i = rnd_i[SAMPLE_WIDTH-1:0];
    end else begin
      sat_i = {rnd_i[AW-1], {(SAMPLE_WIDTH-1){~rnd_i[AW-1]}}};
    end
    if (rnd_q[AW-1:SAMPLE_WIDTH-1] == '0 || rnd_q[AW-1:SAMPLE_WIDTH-1] == '1) begin
      sat_q = rnd_q[SAMPLE_WIDTH-1:0];
    end else begin
      sat_q = {rnd_q[AW-1], {(SAMPLE_WIDTH-1){~rnd_q[AW-1]}}};
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (en_out) begin
      y_i <= bypass_m ? x_i_m : sat_i;
      y_q <= bypass_m ? x_q_m : sat_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/quadrature_frequency_shifter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_frequency_shifter
// Complex frequency shifter: a phase accumulator drives a quarter-wave sine
// table and a complex mixer rotates each I/Q sample.
// ----------------------------------------------------------------------------
// The block takes one complex sample per clock cycle while s_tready is high and
// returns one shifted sample per item through its table read, product and
// round and saturate stages. Each stage holds only while the result further on
// is stalled, so an item is still taken while a finished result waits, as long
// as some stage is empty. The sine and cosine come from the two read ports of
// one table, so the phase accumulator advances once per item except in bypass.
// Writing phase_step through cfg_wen/cfg_wdata sets the shift in turns per
// sample scaled by 2^32; zero passes samples through.
module quadrature_frequency_shifter #(
  parameter int SAMPLE_WIDTH    = qfs_pkg::SAMPLE_WIDTH,
  parameter int PHASE_WIDTH     = qfs_pkg::PHASE_WIDTH,
  parameter int TABLE_ADDR_BITS = qfs_pkg::TABLE_ADDR_BITS,
  localparam int DATA_WIDTH     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write
  input  wire logic                                cfg_wen,
  input  wire logic [qfs_pkg::STEP_WIDTH-1:0]      cfg_wdata,    // phase_step
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [DATA_WIDTH-1:0]               s_tdata,      // in_i, in_q
  // output stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [DATA_WIDTH-1:0]               m_tdata       // out_i, out_q
);

  localparam int IDX_LSB = PHASE_WIDTH - 2 - TABLE_ADDR_BITS;
  localparam logic [TABLE_ADDR_BITS:0] TBL_N = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

  logic [qfs_pkg::STEP_WIDTH-1:0] phase_step;
  logic [PHASE_WIDTH-1:0]         phase_acc;
  logic [PHASE_WIDTH-1:0]         step_aligned;
  logic [PHASE_WIDTH+qfs_pkg::STEP_WIDTH-1:0] step_wide;
  logic                           bypass;

  logic                           accept;
  logic                           en_rd;
  logic                           en_mul;
  logic                           en_out;
  logic                           v_rd;
  logic                           v_mul;
  logic                           v_out;

  logic [1:0]                     sin_quad;
  logic [1:0]                     cos_quad;
  logic [TABLE_ADDR_BITS-1:0]     idx;
  logic [TABLE_ADDR_BITS:0]       sin_addr;
  logic [TABLE_ADDR_BITS:0]       cos_addr;
  logic [qfs_pkg::TRIG_WIDTH-1:0] sin_mag;
  logic [qfs_pkg::TRIG_WIDTH-1:0] cos_mag;
  logic                           sin_neg;
  logic                           cos_neg;
  logic                           bypass_rd;
  logic signed [SAMPLE_WIDTH-1:0] x_i_rd;
  logic signed [SAMPLE_WIDTH-1:0] x_q_rd;
  qfs_pkg::trig_t                 trig;
  logic signed [SAMPLE_WIDTH-1:0] y_i;
  logic signed [SAMPLE_WIDTH-1:0] y_q;

  // phase step register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cfg_wen) begin
      phase_step <= cfg_wdata;
    end
  end

  // align the 32-bit step to the phase width, floor on the right
  assign step_wide    = {phase_step, {PHASE_WIDTH{1'b0}}};
  assign step_aligned = step_wide[PHASE_WIDTH+qfs_pkg::STEP_WIDTH-1:qfs_pkg::STEP_WIDTH];
  assign bypass       = (phase_step == '0);

  // stage enables, a stage moves when it is empty or the next one moves
  assign en_out   = !v_out || m_tready;
  assign en_mul   = !v_mul || en_out;
  assign en_rd    = !v_rd || en_mul;
  assign s_tready = en_rd;
  assign accept   = s_tvalid && s_tready;

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd  <= 1'b0;
      v_mul <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (en_rd) begin
        v_rd <= accept;
      end
      if (en_mul) begin
        v_mul <= v_rd;
      end
      if (en_out) begin
        v_out <= v_mul;
      end
    end
  end

  // phase accumulator, holds in bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept && !bypass) begin
      phase_acc <= phase_acc + step_aligned;
    end
  end

  // table addresses; cosine sits one quadrant ahead
  always_comb begin
    sin_quad = phase_acc[PHASE_WIDTH-1:PHASE_WIDTH-2];
    cos_quad = sin_quad + 2'd1;
    idx      = phase_acc[IDX_LSB +: TABLE_ADDR_BITS];
    sin_addr = sin_quad[0] ? (TBL_N - {1'b0, idx}) : {1'b0, idx};
    cos_addr = cos_quad[0] ? (TBL_N - {1'b0, idx}) : {1'b0, idx};
  end

  qfs_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en_rd),
    .addr_a (sin_addr),
    .addr_b (cos_addr),
    .data_a (sin_mag),
    .data_b (cos_mag)
  );

  // sample and sign registers alongside the table read
  always_ff @(posedge clk) begin
    if (en_rd) begin
      sin_neg   <= sin_quad[1];
      cos_neg   <= cos_quad[1];
      bypass_rd <= bypass;
      x_i_rd    <= s_tdata[SAMPLE_WIDTH-1:0];
      x_q_rd    <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  always_comb begin
    trig.sin_mag = sin_mag;
    trig.cos_mag = cos_mag;
    trig.sin_neg = sin_neg;
    trig.cos_neg = cos_neg;
  end

  qfs_mixer #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mixer (
    .clk    (clk),
    .en_mul (en_mul),
    .en_out (en_out),
    .trig   (trig),
    .bypass (bypass_rd),
    .x_i    (x_i_rd),
    .x_q    (x_q_rd),
    .y_i    (y_i),
    .y_q    (y_q)
  );

  // output item
  assign m_tvalid = v_out;
  assign m_tdata  = DATA_WIDTH'({y_q, y_i});

endmodule
`default_nettype wire
